FILE: design/montgomery_multiply_counted_assert.svh
// Assertion macros shared by the checker of the Montgomery multiplier.
// Depends on nothing; included by the checker file.
`ifndef MONTGOMERY_MULTIPLY_COUNTED_ASSERT_SVH
`define MONTGOMERY_MULTIPLY_COUNTED_ASSERT_SVH

// Same-cycle implication, switched off while reset is held
`define MMC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held
`define MMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also watches reset itself
`define MMC_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/mmc_pkg.sv
// Shared types and constants of the radix-2 Montgomery multiplier.
// No dependencies; imported by the sequencer, the top level, the checker and the bench.
package mmc_pkg;

    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned BIT_COUNT_W = 6;
    localparam int unsigned COUNT_W     = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_COUNT = 1'd1;

    // Reset values of the configuration registers
    localparam logic [CFG_DATA_W-1:0]  MODULUS_RST   = 32'd1;
    localparam logic [BIT_COUNT_W-1:0] BIT_COUNT_RST = 6'd32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_SUM
    } t_state;

    // Strobes from the sequencer to the cell row and the product register
    typedef struct packed {
        logic load;
        logic step;
        logic capture;
    } t_ctrl;

endpackage

FILE: design/mmc_cell.sv
// One bit slice of the Montgomery accumulator, kept in carry-save form.
// Depends on nothing; instantiated once per bit by the top level.
module mmc_cell (
    input  logic i_clk,
    input  logic i_load,
    input  logic i_step,
    input  logic i_a_load,
    input  logic i_b_load,
    input  logic i_n,
    input  logic i_a0,
    input  logic i_q,
    input  logic i_s_in,
    input  logic i_a_in,
    input  logic i_cin,
    output logic o_a,
    output logic o_b,
    output logic o_s,
    output logic o_c,
    output logic o_sum,
    output logic o_cout
);

    logic r_a;
    logic r_b;
    logic r_s;
    logic r_c;
    logic w_x;
    logic w_y;
    logic w_t;
    logic w_carry;

    // 4:2 compression of sum, carry, selected b bit and selected modulus bit
    always_comb begin
        w_x     = i_a0 & r_b;
        w_y     = i_q & i_n;
        w_t     = r_s ^ r_c ^ w_x;
        o_cout  = (r_s & r_c) | (r_s & w_x) | (r_c & w_x);
        o_sum   = w_t ^ w_y ^ i_cin;
        w_carry = (w_t & w_y) | (w_t & i_cin) | (w_y & i_cin);
    end

    // Load operand bits, or take the shifted sum and operand bit from the left
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a <= i_a_load;
            r_b <= i_b_load;
            r_s <= 1'b0;
            r_c <= 1'b0;
        end else if (i_step) begin
            r_a <= i_a_in;
            r_s <= i_s_in;
            r_c <= w_carry;
        end
    end

    assign o_a = r_a;
    assign o_b = r_b;
    assign o_s = r_s;
    assign o_c = r_c;

endmodule

FILE: design/mmc_ctrl.sv
// Sequencer of the Montgomery multiplier: round counter, addition counter,
// handshakes. Depends on mmc_pkg.
module mmc_ctrl
    import mmc_pkg::*;
#(
    parameter int unsigned OPERAND_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    input  logic [BIT_COUNT_W-1:0] i_bit_count,
    input  logic                   i_a0,
    input  logic                   i_q,
    output logic [COUNT_W-1:0]     o_addition_count,
    output t_ctrl                  o_ctrl
);

    localparam int unsigned RW = $clog2(OPERAND_BITS + 3);

    t_state               r_state;
    t_state               n_state;
    logic [RW-1:0]        r_rounds;
    logic [RW-1:0]        n_rounds;
    logic [COUNT_W-1:0]   r_adds;
    logic [COUNT_W-1:0]   n_adds;
    logic [COUNT_W-1:0]   r_count;
    logic                 r_out_valid;
    logic                 w_out_free;
    logic [BIT_COUNT_W-1:0] w_nb;
    logic [COUNT_W:0]     w_add_sum;

    assign w_out_free = !r_out_valid || i_out_ready;

    // Outputs of the state machine
    always_comb begin
        o_in_ready     = 1'b0;
        o_ctrl.capture = 1'b0;
        o_ctrl.step    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_RUN: begin
                o_ctrl.step = 1'b1;
            end
            ST_SUM: begin
                o_in_ready     = w_out_free;
                o_ctrl.capture = w_out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        o_ctrl.load = i_in_valid && o_in_ready;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (r_rounds == '0) n_state = ST_SUM;
            end
            ST_SUM: begin
                if (w_out_free) n_state = i_in_valid ? ST_RUN : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Round count: clamp the bit count to the datapath, two extra rounds
    always_comb begin
        w_nb = (i_bit_count > BIT_COUNT_W'(OPERAND_BITS)) ?
               BIT_COUNT_W'(OPERAND_BITS) : i_bit_count;
        n_rounds = r_rounds;
        if (o_ctrl.load) begin
            n_rounds = RW'(w_nb) + RW'(1);
        end else if (o_ctrl.step) begin
            n_rounds = r_rounds - RW'(1);
        end
    end

    // Saturating count of conditional additions
    always_comb begin
        w_add_sum = {1'b0, r_adds} + (COUNT_W + 1)'(i_a0) + (COUNT_W + 1)'(i_q);
        n_adds    = r_adds;
        if (o_ctrl.load) begin
            n_adds = '0;
        end else if (o_ctrl.step) begin
            n_adds = (w_add_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX
                                                     : w_add_sum[COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_ctrl.capture) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the round and addition counters; latch the count with the product
    always_ff @(posedge i_clk) begin
        r_rounds <= n_rounds;
        r_adds   <= n_adds;
        if (o_ctrl.capture) begin
            r_count <= r_adds;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_addition_count = r_count;

endmodule

FILE: design/montgomery_multiply_counted.sv
// Top level of the radix-2 Montgomery multiplier with addition counter.
// Depends on mmc_pkg, mmc_cell and mmc_ctrl.
//
//  Channel   Handshake                      Payload
//  input     i_in_valid / o_in_ready        i_multiplier, i_multiplicand
//  result    o_out_valid / i_out_ready      o_product, o_addition_count
//  config    i_cfg_we (no wait)             i_cfg_index, i_cfg_data
//
// An item runs min(bit_count, OPERAND_BITS) + 2 rounds in the cell row, one
// round per cycle, then the carry-save accumulator is resolved in the sum state.
// The next item is loaded in the same cycle as the product is captured, so
// items follow back to back while the result side keeps up.
// A result waits in the output register; only a second finished result stalls.
// Reset is synchronous and active low; no clearing pass.
module montgomery_multiply_counted
    import mmc_pkg::*;
#(
    parameter int unsigned OPERAND_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [OPERAND_BITS:0]     i_multiplier,
    input  logic [OPERAND_BITS:0]     i_multiplicand,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [OPERAND_BITS:0]     o_product,
    output logic [COUNT_W-1:0]        o_addition_count
);

    localparam int unsigned W  = OPERAND_BITS + 1;
    localparam int unsigned NW = (OPERAND_BITS > CFG_DATA_W) ? OPERAND_BITS : CFG_DATA_W;

    logic [CFG_DATA_W-1:0]  r_modulus;
    logic [BIT_COUNT_W-1:0] r_bit_count;
    logic [W-1:0]           r_product;
    logic [NW-1:0]          w_mod_ext;
    logic [W-1:0]           w_n;
    logic [W-1:0]           w_a;
    logic [W-1:0]           w_b;
    logic [W-1:0]           w_s;
    logic [W-1:0]           w_c;
    logic [W-1:0]           w_sum;
    logic [W-1:0]           w_cout;
    logic [W-1:0]           w_res;
    logic                   w_q;
    t_ctrl                  w_ctrl;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus   <= MODULUS_RST;
            r_bit_count <= BIT_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODULUS:   r_modulus   <= i_cfg_data;
                CFG_BIT_COUNT: r_bit_count <= i_cfg_data[BIT_COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Modulus trimmed to the operand width, top cell sees zero
    assign w_mod_ext = NW'(r_modulus);
    assign w_n       = {1'b0, w_mod_ext[OPERAND_BITS-1:0]};

    // Quotient bit from the low end of the accumulator
    assign w_q = w_s[0] ^ w_c[0] ^ (w_a[0] & w_b[0]);

    // Row of bit cells; sums shift one place right each round
    for (genvar g = 0; g < W; g++) begin : g_cell
        logic w_s_in;
        logic w_a_in;
        logic w_cin;

        if (g == W - 1) begin : g_top
            assign w_s_in = w_cout[g];
            assign w_a_in = 1'b0;
        end else begin : g_mid
            assign w_s_in = w_sum[g+1];
            assign w_a_in = w_a[g+1];
        end

        if (g == 0) begin : g_low
            assign w_cin = 1'b0;
        end else begin : g_up
            assign w_cin = w_cout[g-1];
        end

        mmc_cell u_cell (
            .i_clk    (i_clk),
            .i_load   (w_ctrl.load),
            .i_step   (w_ctrl.step),
            .i_a_load (i_multiplier[g]),
            .i_b_load (i_multiplicand[g]),
            .i_n      (w_n[g]),
            .i_a0     (w_a[0]),
            .i_q      (w_q),
            .i_s_in   (w_s_in),
            .i_a_in   (w_a_in),
            .i_cin    (w_cin),
            .o_a      (w_a[g]),
            .o_b      (w_b[g]),
            .o_s      (w_s[g]),
            .o_c      (w_c[g]),
            .o_sum    (w_sum[g]),
            .o_cout   (w_cout[g])
        );
    end

    mmc_ctrl #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_bit_count      (r_bit_count),
        .i_a0             (w_a[0]),
        .i_q              (w_q),
        .o_addition_count (o_addition_count),
        .o_ctrl           (w_ctrl)
    );

    // Resolve the carry-save accumulator into the product register
    assign w_res = w_s + w_c;

    always_ff @(posedge i_clk) begin
        if (w_ctrl.capture) begin
            r_product <= w_res;
        end
    end

    assign o_product = r_product;

endmodule

FILE: design/mmc_checker.sv
// Port-level checker of the Montgomery multiplier, bound to the top level.
// Depends on mmc_pkg and montgomery_multiply_counted_assert.svh.
`include "montgomery_multiply_counted_assert.svh"

module mmc_checker
    import mmc_pkg::*;
#(
    parameter int unsigned OPERAND_BITS = 32
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [OPERAND_BITS:0] o_product,
    input logic [COUNT_W-1:0]    o_addition_count
);

    localparam int unsigned ADD_BOUND =
        (2 * (OPERAND_BITS + 2) > 127) ? 127 : 2 * (OPERAND_BITS + 2);

    logic w_in_xfer;
    logic w_out_stall;

    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_out_stall = o_out_valid && !i_out_ready;

    // A waiting result keeps its value
    `MMC_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, w_out_stall, o_out_valid && $stable(o_product) && $stable(o_addition_count), "result changed while stalled")

    // At most two additions per round
    `MMC_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, o_out_valid, o_addition_count <= COUNT_W'(ADD_BOUND), "addition count above round bound")

    // Input ready stays low in the rounds that follow a take
    `MMC_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, w_in_xfer, !o_in_ready ##1 !o_in_ready, "input taken again too soon")

    // Reset leaves no result and an open input
    `MMC_ASSERT_ALWAYS(a_reset_state, i_clk, !i_rst_n, !o_out_valid && o_in_ready, "bad state after reset")

endmodule

bind montgomery_multiply_counted mmc_checker #(
    .OPERAND_BITS (OPERAND_BITS)
) u_mmc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_product        (o_product),
    .o_addition_count (o_addition_count)
);

FILE: tb/sv/montgomery_multiply_counted_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the radix-2 Montgomery multiplier with addition counter.
// Depends on mmc_pkg and montgomery_multiply_counted; drives both channels at random.
module montgomery_multiply_counted_tb;
    import mmc_pkg::*;

    localparam int unsigned OP_W        = 32;
    localparam int unsigned ITEM_TARGET = 1250;
    localparam int unsigned PHASE_ITEMS = 100;
    localparam int unsigned CYCLE_LIMIT = 800000;
    localparam int unsigned IDLE_PCT    = 34;

    typedef struct packed {
        logic [OP_W:0]    product;
        logic [COUNT_W-1:0] additions;
    } t_mont_result;

    typedef struct packed {
        logic               setup;
        logic [OP_W-1:0]    modulus;
        logic [BIT_COUNT_W-1:0] bit_count;
        logic [OP_W:0]      multiplier;
        logic [OP_W:0]      multiplicand;
        logic               known;
        t_mont_result       result;
    } t_plan_row;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = CFG_MODULUS;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    logic [OP_W:0]         i_multiplier   = '0;
    logic [OP_W:0]         i_multiplicand = '0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic [OP_W:0]         o_product;
    logic [COUNT_W-1:0]    o_addition_count;

    // Shadow copy of the configuration the block is running with
    logic [OP_W-1:0]        modulus_cfg   = MODULUS_RST;
    logic [BIT_COUNT_W-1:0] bit_count_cfg = BIT_COUNT_RST;

    t_mont_result pending_products[$];
    t_plan_row    directed_plan[$];
    int unsigned  error_count = 0;
    int unsigned  cycle_count = 0;
    logic         steady      = 1'b0;

    montgomery_multiply_counted #(.OPERAND_BITS(OP_W)) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_multiplier     (i_multiplier),
        .i_multiplicand   (i_multiplicand),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_product        (o_product),
        .o_addition_count (o_addition_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Bit-serial Montgomery product with the running count of additions
    function automatic t_mont_result montgomery_predict(input logic [OP_W:0] a_in,
                                                        input logic [OP_W:0] b_in);
        logic [63:0]   acc;
        logic [64:0]   sum;
        logic [OP_W:0] a;
        logic          wrap;
        logic          quot;
        int unsigned   rounds;
        int unsigned   adds;
        t_mont_result  r;
        a    = a_in;
        acc  = '0;
        adds = 0;
        rounds = ((bit_count_cfg > OP_W) ? OP_W : int'(bit_count_cfg)) + 2;
        for (int unsigned k = 0; k < rounds; k++) begin
            quot = acc[0] ^ (a[0] & b_in[0]);
            wrap = 1'b0;
            if (a[0]) begin
                sum  = {1'b0, acc} + 65'(b_in);
                wrap = wrap ^ sum[64];
                acc  = sum[63:0];
                adds++;
            end
            if (quot) begin
                sum  = {1'b0, acc} + 65'(modulus_cfg);
                wrap = wrap ^ sum[64];
                acc  = sum[63:0];
                adds++;
            end
            acc = {wrap, acc[63:1]};
            a   = a >> 1;
        end
        r.product   = acc[OP_W:0];
        r.additions = (adds > COUNT_MAX) ? COUNT_MAX : COUNT_W'(adds);
        return r;
    endfunction

    function automatic void plan_setup(input logic [OP_W-1:0] modulus,
                                       input logic [BIT_COUNT_W-1:0] bits);
        t_plan_row row;
        row           = '0;
        row.setup     = 1'b1;
        row.modulus   = modulus;
        row.bit_count = bits;
        directed_plan.push_back(row);
    endfunction

    function automatic void plan_item(input logic [OP_W:0] a, input logic [OP_W:0] b,
                                      input logic known, input logic [OP_W:0] product,
                                      input logic [COUNT_W-1:0] additions);
        t_plan_row row;
        row                  = '0;
        row.multiplier       = a;
        row.multiplicand     = b;
        row.known            = known;
        row.result.product   = product;
        row.result.additions = additions;
        directed_plan.push_back(row);
    endfunction

    function automatic logic [OP_W:0] random_operand();
        return {1'($urandom), 32'($urandom)};
    endfunction

    // Offer one operand pair; return at the edge of its transfer
    task automatic send_operands(input logic [OP_W:0] a, input logic [OP_W:0] b,
                                 input logic known, input t_mont_result given);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_multiplier   <= a;
        i_multiplicand <= b;
        do @(posedge i_clk); while (!o_in_ready);
        pending_products.push_back(known ? given : montgomery_predict(a, b));
    endtask

    // Drain the block, then write both registers on consecutive edges
    task automatic apply_setup(input logic [OP_W-1:0] modulus,
                               input logic [BIT_COUNT_W-1:0] bits);
        i_in_valid <= 1'b0;
        while (pending_products.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MODULUS;
        i_cfg_data  <= modulus;
        @(posedge i_clk);
        modulus_cfg  = modulus;
        i_cfg_index <= CFG_BIT_COUNT;
        // upper data bits fall outside the register and must be dropped
        i_cfg_data  <= ($urandom & ~32'h3F) | CFG_DATA_W'(bits);
        @(posedge i_clk);
        bit_count_cfg = bits;
        i_cfg_we     <= 1'b0;
    endtask

    // Sink side: stall at random except during the steady phase
    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Compare every result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_mont_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_products.size() == 0) begin
                $error("unexpected result: product %h, addition_count %0d",
                       o_product, o_addition_count);
                error_count++;
            end else begin
                exp_r = pending_products.pop_front();
                if (o_product !== exp_r.product) begin
                    $error("product: expected %h, got %h", exp_r.product, o_product);
                    error_count++;
                end
                if (o_addition_count !== exp_r.additions) begin
                    $error("addition_count: expected %0d, got %0d",
                           exp_r.additions, o_addition_count);
                    error_count++;
                end
            end
        end
    end

    // Guard against a hung handshake
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned       sent;
        logic [OP_W-1:0]   modulus;
        logic [BIT_COUNT_W-1:0] bits;
        logic [63:0]       span;
        logic [63:0]       mask;
        logic [OP_W:0]     a;
        logic [OP_W:0]     b;
        t_mont_result      none;
        none = '0;

        // Directed table: reset setting first, then the corner settings
        plan_item(33'h0, 33'h0, 1'b1, 33'h0, 7'd0);
        plan_item(33'h0, 33'h1FFFFFFFF, 1'b1, 33'h0, 7'd0);
        plan_item(33'h1FFFFFFFF, 33'h0, 1'b1, 33'h0, 7'd33);
        plan_item(33'h1FFFFFFFF, 33'h1FFFFFFFF, 1'b0, '0, '0);
        plan_item(33'h1, 33'h1, 1'b0, '0, '0);
        plan_setup(32'hFFFFFFFF, 6'd32);
        plan_item(33'h1, 33'h1, 1'b0, '0, '0);
        plan_item(33'h1FFFFFFFD, 33'h1FFFFFFFD, 1'b0, '0, '0);
        plan_item(33'h1FFFFFFFF, 33'h1FFFFFFFF, 1'b0, '0, '0);
        // bit count above the operand width is clamped
        plan_setup(32'hC0000001, 6'd33);
        plan_item(33'h0DEADBEEF, 33'h12345678F, 1'b0, '0, '0);
        plan_item(33'h17FFFFFFF, 33'h000000003, 1'b0, '0, '0);
        // zero modulus with a zero bit count: two rounds only
        plan_setup(32'h0, 6'd0);
        plan_item(33'h1FFFFFFFF, 33'h0, 1'b1, 33'h0, 7'd2);
        plan_item(33'h3, 33'h5, 1'b0, '0, '0);
        // even modulus with the largest bit count the register holds
        plan_setup(32'h12345678, 6'd63);
        plan_item(33'h1FFFFFFFF, 33'h1FFFFFFFF, 1'b0, '0, '0);
        plan_item(33'h0AAAAAAAA, 33'h155555555, 1'b0, '0, '0);
        plan_setup(32'h1, 6'd1);
        plan_item(33'h1FFFFFFFF, 33'h0, 1'b1, 33'h0, 7'd3);
        plan_item(33'h7, 33'h7, 1'b0, '0, '0);
        plan_setup(32'hFFFFFFFF, 6'd0);
        plan_item(33'h1FFFFFFFF, 33'h1FFFFFFFF, 1'b0, '0, '0);

        // Hold reset, then walk the table
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_plan[i]) begin
            if (directed_plan[i].setup) begin
                apply_setup(directed_plan[i].modulus, directed_plan[i].bit_count);
            end else begin
                send_operands(directed_plan[i].multiplier, directed_plan[i].multiplicand,
                              directed_plan[i].known, directed_plan[i].result);
            end
        end

        // Random phases, each under a fresh setting
        sent = 0;
        for (int phase = 0; sent < ITEM_TARGET; phase++) begin
            case ($urandom_range(4))
                0: begin
                    bits    = 6'd32;
                    modulus = 32'hFFFFFFFF;
                end
                1: begin
                    bits    = BIT_COUNT_W'($urandom_range(32, 1));
                    mask    = (64'h1 << bits) - 1;
                    modulus = ($urandom & mask[OP_W-1:0]) | 32'h1;
                end
                2: begin
                    bits    = BIT_COUNT_W'($urandom_range(8, 1));
                    mask    = (64'h1 << bits) - 1;
                    modulus = ($urandom & mask[OP_W-1:0]) | 32'h1;
                end
                3: begin
                    // any modulus, even or zero, and any bit count
                    bits    = BIT_COUNT_W'($urandom_range(63, 0));
                    modulus = ($urandom_range(3) == 0) ? 32'h0 : $urandom;
                end
                default: begin
                    bits    = BIT_COUNT_W'($urandom_range(32, 1));
                    modulus = $urandom | 32'h1;
                end
            endcase
            apply_setup(modulus, bits);
            steady <= (phase == 4);
            repeat (PHASE_ITEMS) begin
                // mostly operands below twice the modulus, the rest unrestricted
                if (modulus != 0 && $urandom_range(99) < 85) begin
                    span = 64'(modulus) << 1;
                    a = (OP_W + 1)'({$urandom, $urandom} % span);
                    b = (OP_W + 1)'({$urandom, $urandom} % span);
                end else begin
                    a = random_operand();
                    b = random_operand();
                end
                send_operands(a, b, 1'b0, none);
                sent++;
            end
        end

        // Drop valid, let every result arrive, then allow trailing cycles
        i_in_valid <= 1'b0;
        while (pending_products.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (error_count == 0 && pending_products.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
